### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define RTTGW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define RTTGW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rttgw_pkg.sv
`default_nettype none
package rttgw_pkg;

  localparam int RTT_W     = 32;
  localparam int WIN_W     = 16;
  localparam int GAIN_W    = 17;
  localparam int SD_W      = 48;
  localparam int CREDIT_W  = 21;
  localparam int BOOST_W   = 16;
  localparam int MUL_A_W   = SD_W + 1;
  localparam int MUL_W     = MUL_A_W + GAIN_W;
  localparam int MUL_STEPS = GAIN_W;
  localparam int DIV_STEPS = SD_W - 1;
  localparam int CNT_W     = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [WIN_W-1:0]   INIT_WINDOW       = 16'd10;
  localparam logic [BOOST_W-1:0] BOOST_MAX         = 16'hFFFF;
  localparam logic [GAIN_W-1:0]  GAIN_ONE          = 17'h10000;
  localparam logic [RTT_W-1:0]   DELAY_LIMIT_RESET = 32'd100;
  localparam logic [GAIN_W-1:0]  EWMA_RESET        = 17'd8192;
  localparam logic [GAIN_W-1:0]  DECR_RESET        = 17'd52429;

  typedef enum logic [1:0] {
    REG_DELAY_LIMIT = 2'd0,
    REG_EWMA        = 2'd1,
    REG_DECR        = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_OUTLIER,
    OP_EWMA_START,
    OP_MUL_STEP,
    OP_SD_UPDATE,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_BETA_START,
    OP_DEC_MUL,
    OP_CREDIT_INC,
    OP_CREDIT_DEC,
    OP_GROW,
    OP_SHRINK,
    OP_FIX
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic outlier;
    logic sd_le_zero;
    logic mul_last;
    logic div_last;
    logic grow_more;
    logic shrink_more;
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/rttgw_if.sv
`default_nettype none
interface rttgw_in_if import rttgw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RTT_W-1:0] send_time;
  logic [RTT_W-1:0] ack_time;

  modport source(output valid, output send_time, output ack_time, input ready);
  modport sink(input valid, input send_time, input ack_time, output ready);
endinterface

interface rttgw_out_if import rttgw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window;
  logic             outlier;
  logic             first_sample;

  modport source(output valid, output window, output outlier, output first_sample,
                 input ready);
  modport sink(input valid, input window, input outlier, input first_sample,
               output ready);
endinterface
`default_nettype wire

### rtl/core/rttgw_ctrl.sv
`default_nettype none
module rttgw_ctrl import rttgw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_free,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       in_ready,
  output logic       out_load
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_MUL_E,
    S_SD_UPD,
    S_CHECK,
    S_DIV,
    S_BETA,
    S_MUL_B,
    S_DEC,
    S_CRED_DEC,
    S_GROW,
    S_SHRINK,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.first) begin
          cmd.op    = OP_FIRST;
          state_nxt = S_OUT;
        end else if (status.outlier) begin
          cmd.op    = OP_OUTLIER;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_EWMA_START;
          state_nxt = S_MUL_E;
        end
      end
      S_MUL_E: begin
        cmd.op = OP_MUL_STEP;
        if (status.mul_last) state_nxt = S_SD_UPD;
      end
      S_SD_UPD: begin
        cmd.op    = OP_SD_UPDATE;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (status.sd_le_zero) begin
          cmd.op    = OP_CREDIT_INC;
          state_nxt = S_GROW;
        end else begin
          cmd.op    = OP_DIV_START;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) state_nxt = S_BETA;
      end
      S_BETA: begin
        cmd.op    = OP_BETA_START;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op = OP_MUL_STEP;
        if (status.mul_last) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.op    = OP_DEC_MUL;
        state_nxt = S_CRED_DEC;
      end
      S_CRED_DEC: begin
        cmd.op    = OP_CREDIT_DEC;
        state_nxt = S_GROW;
      end
      S_GROW: begin
        if (status.grow_more) cmd.op = OP_GROW;
        else                  state_nxt = S_SHRINK;
      end
      S_SHRINK: begin
        if (status.shrink_more) begin
          cmd.op = OP_SHRINK;
        end else begin
          cmd.op    = OP_FIX;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule
`default_nettype wire

### rtl/core/rttgw_dp.sv
`default_nettype none
module rttgw_dp import rttgw_pkg::*; #(
  parameter int MAX_WINDOW    = 65535,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic [RTT_W-1:0]  send_time,
  input  logic [RTT_W-1:0]  ack_time,
  input  logic [RTT_W-1:0]  delay_limit,
  input  logic [GAIN_W-1:0] ewma_gain,
  input  logic [GAIN_W-1:0] decrease_gain,
  output dp_status_t        status,
  output logic [WIN_W-1:0]  window,
  output logic              outlier,
  output logic              first_sample
);

  localparam int XW = RTT_W + 1 + FRACTION_BITS;
  localparam int XE = (XW > SD_W) ? XW : SD_W;
  localparam int FW = FRACTION_BITS + 1;
  localparam int BG_W = MUL_W - 16;
  localparam logic [XE-1:0] SD_MAX_E = {{(XE-SD_W+1){1'b0}}, {(SD_W-1){1'b1}}};
  localparam logic [XE-1:0] SD_MIN_E = {{(XE-SD_W+1){1'b1}}, {(SD_W-1){1'b0}}};
  localparam logic [FW-1:0] ONE_F = FW'(1) << FRACTION_BITS;
  localparam logic [DIV_STEPS-1:0] G_CAP = DIV_STEPS'(1) << (FRACTION_BITS + 16);
  localparam logic [WIN_W-1:0] MAX_WIN = WIN_W'(MAX_WINDOW);

  // architectural state
  logic [WIN_W-1:0]           window_r, window_nxt;
  logic signed [CREDIT_W-1:0] credit_r, credit_nxt;
  logic [RTT_W-1:0]           last_r, last_nxt;
  logic [RTT_W-1:0]           lowest_r, lowest_nxt;
  logic signed [SD_W-1:0]     sd_r, sd_nxt;
  logic [BOOST_W-1:0]         boost_r, boost_nxt;
  // working registers
  logic [RTT_W-1:0]           rtt_r, rtt_nxt;
  logic                       first_r, first_nxt;
  logic                       outl_r, outl_nxt;
  logic signed [MUL_W-1:0]    mc_r, mc_nxt;
  logic [GAIN_W-1:0]          mb_r, mb_nxt;
  logic signed [MUL_W-1:0]    acc_r, acc_nxt;
  logic [DIV_STEPS-1:0]       q_r, q_nxt;
  logic [RTT_W-1:0]           rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [WIN_W-1:0]           dec_r, dec_nxt;

  logic [RTT_W-1:0]           rtt_raw;
  logic [RTT_W-1:0]           lowest_min;
  logic signed [RTT_W:0]      diff;
  logic signed [XE-1:0]       x_ext;
  logic signed [SD_W-1:0]     x_sat;
  logic signed [MUL_A_W-1:0]  d_err;
  logic [GAIN_W-1:0]          alpha;
  logic [GAIN_W-1:0]          beta;
  logic signed [CREDIT_W-1:0] w_s;
  logic [RTT_W:0]             rem_sh;
  logic [BG_W-1:0]            bg;
  logic [FW-1:0]              factor;
  logic [WIN_W+FW-1:0]        dec_prod;
  logic [DIV_STEPS-1:0]       g_cap;

  assign rtt_raw    = ack_time - send_time;
  assign lowest_min = (rtt_r < lowest_r) ? rtt_r : lowest_r;
  assign diff       = $signed({1'b0, rtt_r}) - $signed({1'b0, last_r});
  assign x_ext      = XE'(diff) <<< FRACTION_BITS;
  assign x_sat      = (x_ext > $signed(SD_MAX_E)) ? SD_MAX_E[SD_W-1:0] :
                      (x_ext < $signed(SD_MIN_E)) ? SD_MIN_E[SD_W-1:0] :
                      x_ext[SD_W-1:0];
  assign d_err      = $signed({x_sat[SD_W-1], x_sat}) - $signed({sd_r[SD_W-1], sd_r});
  assign alpha      = (ewma_gain > GAIN_ONE) ? GAIN_ONE : ewma_gain;
  assign beta       = (decrease_gain > GAIN_ONE) ? GAIN_ONE : decrease_gain;
  assign w_s        = $signed({{(CREDIT_W-WIN_W){1'b0}}, window_r});
  assign rem_sh     = {rem_r, q_r[DIV_STEPS-1]};
  assign bg         = acc_r[MUL_W-1:16];
  assign factor     = (bg < {{(BG_W-FW){1'b0}}, ONE_F}) ? (ONE_F - bg[FW-1:0]) : '0;
  assign dec_prod   = window_r * factor;
  assign g_cap      = (q_r > G_CAP) ? G_CAP : q_r;

  always_comb begin
    window_nxt = window_r;
    credit_nxt = credit_r;
    last_nxt   = last_r;
    lowest_nxt = lowest_r;
    sd_nxt     = sd_r;
    boost_nxt  = boost_r;
    rtt_nxt    = rtt_r;
    first_nxt  = first_r;
    outl_nxt   = outl_r;
    mc_nxt     = mc_r;
    mb_nxt     = mb_r;
    acc_nxt    = acc_r;
    q_nxt      = q_r;
    rem_nxt    = rem_r;
    cnt_nxt    = cnt_r;
    dec_nxt    = dec_r;
    case (cmd.op)
      OP_LOAD: begin
        // zero rtt counts as one
        rtt_nxt = (rtt_raw == '0) ? RTT_W'(1) : rtt_raw;
      end
      OP_FIRST: begin
        lowest_nxt = rtt_r;
        last_nxt   = rtt_r;
        first_nxt  = 1'b1;
        outl_nxt   = 1'b0;
      end
      OP_OUTLIER: begin
        lowest_nxt = lowest_min;
        last_nxt   = rtt_r;
        boost_nxt  = BOOST_W'(1);
        window_nxt = (window_r[WIN_W-1:1] == '0) ? WIN_W'(1) : {1'b0, window_r[WIN_W-1:1]};
        credit_nxt = '0;
        first_nxt  = 1'b0;
        outl_nxt   = 1'b1;
      end
      OP_EWMA_START: begin
        lowest_nxt = lowest_min;
        last_nxt   = rtt_r;
        first_nxt  = 1'b0;
        outl_nxt   = 1'b0;
        mc_nxt     = MUL_W'(d_err);
        mb_nxt     = alpha;
        acc_nxt    = '0;
        cnt_nxt    = '0;
      end
      OP_MUL_STEP: begin
        if (mb_r[0]) acc_nxt = acc_r + mc_r;
        mc_nxt  = mc_r <<< 1;
        mb_nxt  = mb_r >> 1;
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_SD_UPDATE: begin
        sd_nxt = sd_r + $signed(acc_r[16 +: SD_W]);
      end
      OP_DIV_START: begin
        boost_nxt = BOOST_W'(1);
        q_nxt     = sd_r[DIV_STEPS-1:0];
        rem_nxt   = '0;
        cnt_nxt   = '0;
      end
      OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, lowest_r}) begin
          rem_nxt = rem_sh[RTT_W-1:0] - lowest_r;
          q_nxt   = {q_r[DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[RTT_W-1:0];
          q_nxt   = {q_r[DIV_STEPS-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_BETA_START: begin
        mc_nxt  = $signed({{(MUL_W-DIV_STEPS){1'b0}}, g_cap});
        mb_nxt  = beta;
        acc_nxt = '0;
        cnt_nxt = '0;
      end
      OP_DEC_MUL: begin
        dec_nxt = dec_prod[FRACTION_BITS +: WIN_W];
      end
      OP_CREDIT_INC: begin
        // credit grows by four times the boost
        credit_nxt = credit_r + $signed({{(CREDIT_W-BOOST_W-2){1'b0}}, boost_r, 2'b00});
        if (boost_r != BOOST_MAX) boost_nxt = boost_r + BOOST_W'(1);
      end
      OP_CREDIT_DEC: begin
        credit_nxt = credit_r - $signed({{(CREDIT_W-WIN_W){1'b0}}, dec_r});
      end
      OP_GROW: begin
        if (window_r >= MAX_WIN) begin
          credit_nxt = w_s - CREDIT_W'(1);
        end else begin
          window_nxt = window_r + WIN_W'(1);
          credit_nxt = credit_r - w_s - CREDIT_W'(1);
        end
      end
      OP_SHRINK: begin
        window_nxt = window_r - WIN_W'(1);
        credit_nxt = credit_r + w_s - CREDIT_W'(1);
      end
      OP_FIX: begin
        if (window_r == '0) begin
          window_nxt = WIN_W'(1);
          credit_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= INIT_WINDOW;
      credit_r <= '0;
      last_r   <= '0;
      lowest_r <= '0;
      sd_r     <= '0;
      boost_r  <= BOOST_W'(1);
      first_r  <= 1'b0;
      outl_r   <= 1'b0;
    end else begin
      window_r <= window_nxt;
      credit_r <= credit_nxt;
      last_r   <= last_nxt;
      lowest_r <= lowest_nxt;
      sd_r     <= sd_nxt;
      boost_r  <= boost_nxt;
      first_r  <= first_nxt;
      outl_r   <= outl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rtt_r <= rtt_nxt;
    mc_r  <= mc_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    dec_r <= dec_nxt;
  end

  assign status.first       = (lowest_r == '0);
  assign status.outlier     = (rtt_r > delay_limit);
  assign status.sd_le_zero  = sd_r[SD_W-1] | (sd_r == '0);
  assign status.mul_last    = (cnt_r == CNT_W'(MUL_STEPS - 1));
  assign status.div_last    = (cnt_r == CNT_W'(DIV_STEPS - 1));
  assign status.grow_more   = (credit_r >= w_s);
  assign status.shrink_more = (window_r != '0) && (credit_r <= -w_s);

  assign window       = window_r;
  assign outlier      = outl_r;
  assign first_sample = first_r;

endmodule
`default_nettype wire

### rtl/core/rtt_gradient_window_control_core.sv
// rtt-gradient congestion window control
// in_ch takes one acknowledgement word (send_time, ack_time, wrapping ms);
// out_ch gives one word per acknowledgement: the window after it, an
// outlier flag and a first-sample flag. valid/ready on both channels.
// cfg_* is an apb-style write/read port for the outlier threshold (0x0),
// ewma_gain (0x4) and decrease_gain (0x8); pready is tied high.
// a first sample or an outlier goes straight to the output; a gradient at or
// below zero takes the ewma multiply and the credit walk; a positive gradient
// also takes the divider, a second multiply and the credit decrease.
// the 17-step shift-add multiplier (used twice) and the 47-step restoring
// divider do the arithmetic, and the credit walk moves the window by one
// per step. one word is in work at a time.
// a finished word waits in the output register; in_ch.ready rises again once
// it is loaded there, so one more word can finish behind a stalled receiver.
// reset (rst_n, synchronous) gives window 10, credit 0, no rtt sample, boost 1
// and the register reset values.
`default_nettype none
`include "assert_macros.svh"
module rtt_gradient_window_control_core import rttgw_pkg::*; #(
  parameter int MAX_WINDOW    = 65535,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rttgw_in_if.sink              in_ch,
  rttgw_out_if.source           out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [RTT_W-1:0]  delay_limit_r;
  logic [GAIN_W-1:0] ewma_gain_r;
  logic [GAIN_W-1:0] decr_gain_r;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  logic              out_valid_r;
  logic [WIN_W-1:0]  out_window_r;
  logic              out_outlier_r;
  logic              out_first_r;

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic              in_ready;
  logic              in_fire;
  logic              out_load;
  logic              out_free;
  logic [WIN_W-1:0]  dp_window;
  logic              dp_outlier;
  logic              dp_first;

  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_limit_r <= DELAY_LIMIT_RESET;
      ewma_gain_r   <= EWMA_RESET;
      decr_gain_r   <= DECR_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_DELAY_LIMIT: delay_limit_r <= cfg_pwdata;
        REG_EWMA:        ewma_gain_r   <= cfg_pwdata[GAIN_W-1:0];
        REG_DECR:        decr_gain_r   <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DELAY_LIMIT: cfg_prdata = delay_limit_r;
      REG_EWMA:        cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, ewma_gain_r};
      REG_DECR:        cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, decr_gain_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid & in_ready;
  assign out_free    = ~out_valid_r | out_ch.ready;

  rttgw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd),
    .in_ready (in_ready),
    .out_load (out_load)
  );

  rttgw_dp #(
    .MAX_WINDOW    (MAX_WINDOW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .send_time     (in_ch.send_time),
    .ack_time      (in_ch.ack_time),
    .delay_limit   (delay_limit_r),
    .ewma_gain     (ewma_gain_r),
    .decrease_gain (decr_gain_r),
    .status        (status),
    .window        (dp_window),
    .outlier       (dp_outlier),
    .first_sample  (dp_first)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_window_r  <= dp_window;
      out_outlier_r <= dp_outlier;
      out_first_r   <= dp_first;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.window       = out_window_r;
  assign out_ch.outlier      = out_outlier_r;
  assign out_ch.first_sample = out_first_r;

  `RTTGW_ASSERT_NOW(a_win_range, clk, rst_n, out_ch.valid, (out_ch.window != '0) && (out_ch.window <= WIN_W'(MAX_WINDOW)), "window out of range")
  `RTTGW_ASSERT_NOW(a_flags_excl, clk, rst_n, out_ch.valid, !(out_ch.outlier && out_ch.first_sample), "outlier and first sample both set")
  `RTTGW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, !in_ready && !out_load, "accepted word not held in work")
  `RTTGW_ASSERT_NOW(a_load_free, clk, rst_n, out_load, out_free, "output register overwritten")

endmodule
`default_nettype wire
